// File: hw/rtl/bps_pkg.sv
// Shared constants and types for the bitmap prime sieve.
// Used by bps_map, bitmap_prime_sieve_top and the bench; no dependencies.
package bps_pkg;

    localparam int SIEVE_SIZE = 65536;
    localparam int MAP_AW     = $clog2(SIEVE_SIZE);
    localparam int CAND_W     = 16;
    localparam int NEXT_W     = CAND_W + 1;

    typedef logic [MAP_AW-1:0] t_addr;
    typedef logic [CAND_W-1:0] t_cand;
    typedef logic [NEXT_W-1:0] t_next;

    // largest usable limit: the register width or the map depth, whichever is smaller
    localparam t_next LIM_CAP = (SIEVE_SIZE - 1 > 65535) ? t_next'(65535)
                                                         : t_next'(SIEVE_SIZE - 1);
    localparam t_addr ADDR_TOP = t_addr'(SIEVE_SIZE - 1);

    typedef struct packed {
        logic  en;
        t_addr addr;
        logic  data;
    } t_map_wr;

endpackage

// File: hw/rtl/bps_map.sv
// Composite map: one bit per number, one write and one registered read port.
// Depends on bps_pkg.
module bps_map (
    input  logic              i_clk,
    input  bps_pkg::t_map_wr  i_wr,
    input  logic              i_rd_en,
    input  bps_pkg::t_addr    i_rd_addr,
    output logic              o_rd_data
);
    import bps_pkg::*;

    logic r_mem [SIEVE_SIZE];
    logic r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/bitmap_prime_sieve_top.sv
// Sieve of Eratosthenes top level: step sequencer, limit register, result register.
// Depends on bps_pkg and bps_map.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+------------------------------------
//  in       | input     | i_in_valid / o_in_stall    | i_restart
//  out      | output    | o_out_valid / i_out_stall  | o_candidate o_is_prime o_in_range o_last
//  cfg      | input     | i_cfg_valid / o_cfg_ready  | i_cfg_data (upper_limit)
//
// A step request passes through accept and map test. A prime whose double is within
// the limit then marks each multiple in turn, floor(limit/candidate) - 1 map writes,
// and then loads the result.
// A restart first clears the map from 0 up to the highest address written since
// the last clear (one entry a cycle), then reads candidate 2 in S_READ.
// After reset the whole map is cleared, with requests stalled.
// The result register lets a new request be accepted while a result is stalled;
// a step only finishes once that register is free.
module bitmap_prime_sieve_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_restart,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output bps_pkg::t_cand       o_candidate,
    output logic                 o_is_prime,
    output logic                 o_in_range,
    output logic                 o_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [15:0]          i_cfg_data
);
    import bps_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_TEST,
        S_MARK,
        S_EMIT
    } t_state;

    t_state      r_state;
    logic [15:0] r_limit;
    t_next       r_next;
    t_next       r_j;
    t_cand       r_step;
    t_addr       r_clr;
    t_addr       r_dirty_top;
    logic        r_clr_restart;

    t_cand       r_pend_cand;
    logic        r_pend_prime;
    logic        r_pend_inr;
    logic        r_pend_last;

    logic        r_out_valid;
    t_cand       r_out_cand;
    logic        r_out_prime;
    logic        r_out_inr;
    logic        r_out_last;

    t_map_wr     map_wr;
    logic        map_rd_en;
    logic        map_rd_data;

    t_next       lim;
    logic        in_accept;
    logic        can_load;
    logic        c_inr;
    logic        c_prime;
    logic        c_last;
    t_next       c_double;
    t_next       n_j;

    assign lim = (t_next'(r_limit) > LIM_CAP) ? LIM_CAP : t_next'(r_limit);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign can_load    = !r_out_valid || !i_out_stall;

    // map test, valid in S_TEST (read issued on the previous edge)
    assign c_inr    = (r_next >= t_next'(2)) && (r_next <= lim);
    assign c_prime  = c_inr && !map_rd_data;
    assign c_last   = c_inr && (r_next == lim);
    assign c_double = {r_next[NEXT_W-2:0], 1'b0};
    assign n_j      = r_j + t_next'(r_step);

    // The FSM never overlaps a read with a write, so no forwarding is needed.
    always_comb begin
        map_wr.en   = (r_state == S_CLEAR) || (r_state == S_MARK);
        map_wr.addr = (r_state == S_MARK) ? t_addr'(r_j) : r_clr;
        map_wr.data = (r_state == S_MARK);
    end

    assign map_rd_en = (in_accept && !i_restart) || (r_state == S_READ);

    bps_map u_map (
        .i_clk     (i_clk),
        .i_wr      (map_wr),
        .i_rd_en   (map_rd_en),
        .i_rd_addr (t_addr'(r_next)),
        .o_rd_data (map_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_limit       <= 16'd100;
            r_next        <= t_next'(2);
            r_clr         <= '0;
            r_dirty_top   <= ADDR_TOP;
            r_clr_restart <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + t_addr'(1);
                    if (r_clr == r_dirty_top) begin
                        r_clr       <= '0;
                        r_dirty_top <= '0;
                        r_state     <= r_clr_restart ? S_READ : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        if (i_restart) begin
                            r_next        <= t_next'(2);
                            r_clr         <= '0;
                            r_clr_restart <= 1'b1;
                            r_state       <= S_CLEAR;
                        end else begin
                            r_state <= S_TEST;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_TEST;
                end
                S_TEST: begin
                    r_pend_cand  <= r_next[CAND_W-1:0];
                    r_pend_prime <= c_prime;
                    r_pend_inr   <= c_inr;
                    r_pend_last  <= c_last;
                    r_j          <= c_double;
                    r_step       <= r_next[CAND_W-1:0];
                    if (c_inr) begin
                        r_next <= r_next + t_next'(1);
                    end
                    if (c_prime && (c_double <= lim)) begin
                        r_state <= S_MARK;
                    end else if (can_load) begin
                        r_out_valid <= 1'b1;
                        r_out_cand  <= r_next[CAND_W-1:0];
                        r_out_prime <= c_prime;
                        r_out_inr   <= c_inr;
                        r_out_last  <= c_last;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_MARK: begin
                    r_j <= n_j;
                    if (t_addr'(r_j) > r_dirty_top) begin
                        r_dirty_top <= t_addr'(r_j);
                    end
                    if (n_j > lim) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (can_load) begin
                        r_out_valid <= 1'b1;
                        r_out_cand  <= r_pend_cand;
                        r_out_prime <= r_pend_prime;
                        r_out_inr   <= r_pend_inr;
                        r_out_last  <= r_pend_last;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_candidate = r_out_cand;
    assign o_is_prime  = r_out_prime;
    assign o_in_range  = r_out_inr;
    assign o_last      = r_out_last;

    // an accepted request always leaves the block busy in the following cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("request accepted but block not busy next cycle");

    // map port never reads and writes in the same cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(map_rd_en && map_wr.en))
        else $error("map read and write overlap");

    // marks stay within the effective limit
    a_mark_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK) |-> (r_j <= lim))
        else $error("mark address beyond limit");

    // a prime or final result is always in range
    a_prime_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_is_prime || o_last)) |-> o_in_range)
        else $error("prime or last flagged outside range");

endmodule

// File: bench/bitmap_prime_sieve_top_test.sv
// Self-checking bench for bitmap_prime_sieve_top: directed table, then random sieve runs.
// Step results are predicted by a behavioral sieve kept in the bench. Depends on bps_pkg.
`timescale 1ns / 100ps

module bitmap_prime_sieve_top_test;
    import bps_pkg::*;

    typedef struct packed {
        t_cand candidate;
        logic  is_prime;
        logic  in_range;
        logic  last;
    } t_step_res;

    typedef enum logic {ROW_STEP, ROW_LIMIT} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic        restart;
        logic [15:0] limit;
        logic        typed;
        t_step_res   want;
    } t_stim_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        i_restart   = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [15:0] i_cfg_data  = 16'd0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_cand       o_candidate;
    logic        o_is_prime;
    logic        o_in_range;
    logic        o_last;
    logic        o_cfg_ready;

    // bench copy of the sieve
    bit          composite_bits [0:SIEVE_SIZE-1];
    int unsigned marked_top  = 0;
    t_next       sieve_next  = t_next'(2);
    logic [15:0] sieve_limit = 16'd100;

    t_step_res   step_results_due [$];
    t_step_res   result_head;
    int unsigned mismatch_count = 0;

    int unsigned tx_idle_pct = 8;
    int unsigned rx_idle_pct = 74;
    int unsigned hold_requests = 0;
    int unsigned hold_seen = 0;
    int unsigned rx_hold_left = 0;

    // rows with a typed result can be read off by hand; the rest use the predictor
    t_stim_row directed_rows [0:25] = '{
        '{ROW_STEP,  1'b0, 16'd0,     1'b1, '{16'd2, 1'b1, 1'b1, 1'b0}},
        '{ROW_STEP,  1'b0, 16'd0,     1'b1, '{16'd3, 1'b1, 1'b1, 1'b0}},
        '{ROW_STEP,  1'b0, 16'd0,     1'b1, '{16'd4, 1'b0, 1'b1, 1'b0}},
        '{ROW_STEP,  1'b1, 16'd0,     1'b1, '{16'd2, 1'b1, 1'b1, 1'b0}},
        '{ROW_LIMIT, 1'b0, 16'd0,     1'b0, '0},
        '{ROW_STEP,  1'b1, 16'd0,     1'b1, '{16'd2, 1'b0, 1'b0, 1'b0}},
        '{ROW_STEP,  1'b0, 16'd0,     1'b1, '{16'd2, 1'b0, 1'b0, 1'b0}},
        '{ROW_LIMIT, 1'b0, 16'd1,     1'b0, '0},
        '{ROW_STEP,  1'b0, 16'd0,     1'b1, '{16'd2, 1'b0, 1'b0, 1'b0}},
        '{ROW_LIMIT, 1'b0, 16'd2,     1'b0, '0},
        '{ROW_STEP,  1'b1, 16'd0,     1'b1, '{16'd2, 1'b1, 1'b1, 1'b1}},
        '{ROW_STEP,  1'b0, 16'd0,     1'b1, '{16'd3, 1'b0, 1'b0, 1'b0}},
        '{ROW_STEP,  1'b0, 16'd0,     1'b1, '{16'd3, 1'b0, 1'b0, 1'b0}},
        // raise the limit without a restart: stale map, 4 reads as prime
        '{ROW_LIMIT, 1'b0, 16'd5,     1'b0, '0},
        '{ROW_STEP,  1'b0, 16'd0,     1'b0, '0},
        '{ROW_STEP,  1'b0, 16'd0,     1'b0, '0},
        '{ROW_STEP,  1'b0, 16'd0,     1'b0, '0},
        '{ROW_LIMIT, 1'b0, 16'hFFFF,  1'b0, '0},
        '{ROW_STEP,  1'b1, 16'd0,     1'b1, '{16'd2, 1'b1, 1'b1, 1'b0}},
        '{ROW_STEP,  1'b0, 16'd0,     1'b1, '{16'd3, 1'b1, 1'b1, 1'b0}},
        '{ROW_STEP,  1'b0, 16'd0,     1'b1, '{16'd4, 1'b0, 1'b1, 1'b0}},
        '{ROW_STEP,  1'b0, 16'd0,     1'b1, '{16'd5, 1'b1, 1'b1, 1'b0}},
        // drop the limit below the current candidate
        '{ROW_LIMIT, 1'b0, 16'd3,     1'b0, '0},
        '{ROW_STEP,  1'b0, 16'd0,     1'b1, '{16'd6, 1'b0, 1'b0, 1'b0}},
        '{ROW_STEP,  1'b1, 16'd0,     1'b1, '{16'd2, 1'b1, 1'b1, 1'b0}},
        '{ROW_STEP,  1'b0, 16'd0,     1'b1, '{16'd3, 1'b1, 1'b1, 1'b1}}
    };

    bitmap_prime_sieve_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_restart   (i_restart),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_candidate (o_candidate),
        .o_is_prime  (o_is_prime),
        .o_in_range  (o_in_range),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_step_res predict_sieve_step(input bit rst_bit);
        t_step_res   r;
        int unsigned lim;
        int unsigned c;
        int unsigned j;
        lim = 32'(sieve_limit);
        if (lim > SIEVE_SIZE - 1) lim = SIEVE_SIZE - 1;
        if (rst_bit) begin
            for (j = 0; j <= marked_top; j++) composite_bits[t_addr'(j)] = 1'b0;
            marked_top = 0;
            sieve_next = t_next'(2);
        end
        c = 32'(sieve_next);
        r.candidate = t_cand'(c);
        r.in_range  = (c >= 2) && (c <= lim);
        r.is_prime  = 1'b0;
        r.last      = 1'b0;
        if (r.in_range) begin
            r.is_prime = !composite_bits[t_addr'(c)];
            if (r.is_prime) begin
                for (j = 2 * c; j <= lim; j += c) begin
                    composite_bits[t_addr'(j)] = 1'b1;
                    if (j > marked_top) marked_top = j;
                end
            end
            r.last     = (c == lim);
            sieve_next = t_next'(c + 1);
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // result checker: sampled at the edge, before the block updates its outputs
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (step_results_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual candidate %0d",
                         $time, o_candidate);
                mismatch_count++;
            end else begin
                result_head = step_results_due.pop_front();
                check_field("candidate", 32'(result_head.candidate), 32'(o_candidate));
                check_field("is_prime",  32'(result_head.is_prime),  32'(o_is_prime));
                check_field("in_range",  32'(result_head.in_range),  32'(o_in_range));
                check_field("last",      32'(result_head.last),      32'(o_last));
            end
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen    = hold_requests;
            rx_hold_left = 12000;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    task automatic send_step(input bit rst_bit, input bit typed, input t_step_res typed_res);
        t_step_res want;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart  <= rst_bit;
        do @(posedge i_clk); while (o_in_stall);
        want = predict_sieve_step(rst_bit);
        if (typed) want = typed_res;
        step_results_due.push_back(want);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (step_results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sieve_limit = value;
    endtask

    // mostly whole sieve runs from a restart; some continue a run under a new limit,
    // and a few stray restarts break runs in the middle
    task automatic run_random_sieves(input int unsigned item_target);
        int unsigned sent;
        int unsigned steps;
        int unsigned k;
        int unsigned pick;
        bit          fresh;
        logic [15:0] lim;
        sent = 0;
        while (sent < item_target) begin
            wait_idle();
            if ($urandom_range(99) < 80) begin
                pick = $urandom_range(99);
                if (pick < 6)       lim = 16'($urandom_range(0, 3));
                else if (pick < 76) lim = 16'($urandom_range(4, 60));
                else if (pick < 95) lim = 16'($urandom_range(61, 400));
                else                lim = 16'($urandom_range(401, 3000));
                write_limit(lim);
            end
            fresh = ($urandom_range(9) != 0);
            if (sieve_limit < 2)        steps = $urandom_range(1, 3);
            else if (sieve_limit <= 60) steps = sieve_limit - 1 + $urandom_range(0, 3);
            else                        steps = $urandom_range(5, 40);
            for (k = 0; k < steps; k++) begin
                send_step((k == 0 && fresh) || ($urandom_range(39) == 0), 1'b0, '0);
                sent++;
            end
        end
    endtask

    initial begin
        int row;
        int k;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < $size(directed_rows); row++) begin
            if (directed_rows[row].kind == ROW_LIMIT) begin
                wait_idle();
                write_limit(directed_rows[row].limit);
            end else begin
                send_step(directed_rows[row].restart, directed_rows[row].typed,
                          directed_rows[row].want);
            end
        end

        run_random_sieves(620);

        // hold the output off long enough that the block backs up into its input
        wait_idle();
        hold_requests++;
        for (k = 0; k < 12; k++) send_step(k == 0, 1'b0, '0);
        wait_idle();

        tx_idle_pct = 74;
        rx_idle_pct = 8;
        run_random_sieves(620);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random_sieves(600);

        wait_idle();
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("bitmap_prime_sieve_top_test: PASS");
        else
            $display("bitmap_prime_sieve_top_test: FAIL");
        $finish;
    end

    initial begin
        #200ms;
        $display("bitmap_prime_sieve_top_test: FAIL");
        $finish;
    end

endmodule

// File: bitmap_prime_sieve_top.f
hw/rtl/bps_pkg.sv
hw/rtl/bps_map.sv
hw/rtl/bitmap_prime_sieve_top.sv
bench/bitmap_prime_sieve_top_test.sv
